// ----- hw/rtl/rpot_pkg.sv -----
// Shared types and constants for the row placement occupancy table.
// Holds operation, status, entry-kind and register codes, the controller
// state type and the command and status structs between controller and datapath.
package rpot_pkg;

  // Field widths fixed by the item and register formats.
  localparam int unsigned COORD_W = 32;
  localparam int unsigned SIZE_W  = 31;
  localparam int unsigned PITCH_W = 20;
  localparam int unsigned CFG_IDX_W = 3;

  // Divider operand widths: every dividend the block forms fits in 35 signed bits.
  localparam int unsigned DIV_W  = 35;
  localparam int unsigned QUOT_W = 36;
  localparam int unsigned CMP_W  = 37;

  // Entry kinds as stored in the kind memory.
  localparam logic [1:0] KIND_EMPTY = 2'd0;
  localparam logic [1:0] KIND_OBST  = 2'd1;
  localparam logic [1:0] KIND_CELL  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DIE_LEFT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIE_BOTTOM  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIE_RIGHT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIE_TOP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SITE_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SITE_HEIGHT = 3'd5;

  typedef enum logic [1:0] {
    FN_ADD_OBST = 2'd0,
    FN_CHECK    = 2'd1,
    FN_COMMIT   = 2'd2,
    FN_UNCOMMIT = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_OFF_GRID  = 3'd1,
    ST_OUTSIDE   = 3'd2,
    ST_OBSTACLE  = 3'd3,
    ST_OVERLAP   = 3'd4,
    ST_NOT_FOUND = 3'd5,
    ST_FULL      = 3'd6,
    ST_NO_ROWS   = 3'd7
  } status_e;

  // Which quotient the shared divider is working on.
  typedef enum logic [2:0] {
    DV_ROWS,
    DV_X,
    DV_Y,
    DV_NEED,
    DV_LAST
  } div_sel_e;

  typedef enum logic [3:0] {
    CS_CLEAR,
    CS_IDLE,
    CS_DIV_START,
    CS_DIV_WAIT,
    CS_PLAN,
    CS_SCAN_RD,
    CS_SCAN_EV,
    CS_POST,
    CS_WR_RD,
    CS_WR_EV,
    CS_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic     clear_step;
    logic     load_in;
    logic     div_start;
    logic     div_capture;
    div_sel_e div_sel;
    logic     plan;
    logic     scan_eval;
    logic     post;
    logic     wr_eval;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic func_add;
    logic div_done;
    logic plan_finish;
    logic last_ent;
    logic last_row;
    logic post_finish;
    logic wr_hit;
    logic out_free;
  } dp_status_t;

endpackage

// ----- hw/rtl/rpot_if.sv -----
// Handshake interfaces for the occupancy table: operation items, result items
// and configuration writes. Payload widths come from rpot_pkg.
interface rpot_item_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          func;
  logic signed [rpot_pkg::COORD_W-1:0] pos_x;
  logic signed [rpot_pkg::COORD_W-1:0] pos_y;
  logic [rpot_pkg::SIZE_W-1:0]         size_w;
  logic [rpot_pkg::SIZE_W-1:0]         size_h;
  modport source (output valid, func, pos_x, pos_y, size_w, size_h, input ready);
  modport sink (input valid, func, pos_x, pos_y, size_w, size_h, output ready);
endinterface

interface rpot_res_if;
  logic       valid;
  logic       ready;
  logic       ok;
  logic [2:0] status;
  modport source (output valid, ok, status, input ready);
  modport sink (input valid, ok, status, output ready);
endinterface

interface rpot_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rpot_pkg::CFG_IDX_W-1:0]    index;
  logic [rpot_pkg::COORD_W-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/rpot_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Used for the entry kind and entry interval stores; no dependencies.
module rpot_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/rpot_div.sv -----
// Iterative signed floor divider, one quotient bit per cycle, shared by all
// row and grid computations. Depends on rpot_pkg for operand widths.
module rpot_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [rpot_pkg::DIV_W-1:0]   dividend_i,
  input  logic [rpot_pkg::PITCH_W-1:0]        divisor_i,
  output logic                                done_o,
  output logic signed [rpot_pkg::QUOT_W-1:0]  quot_o,
  output logic [rpot_pkg::PITCH_W-1:0]        rem_o
);

  localparam int unsigned DW    = rpot_pkg::DIV_W;
  localparam int unsigned PW    = rpot_pkg::PITCH_W;
  localparam int unsigned QW    = rpot_pkg::QUOT_W;
  localparam int unsigned CNT_W = $clog2(DW + 1);

  logic             busy_q, fix_q, done_q, neg_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DW-1:0]    quo_q;
  logic [PW-1:0]    rem_q, dvs_q;
  logic [QW-1:0]    quot_out_q;
  logic [PW-1:0]    rem_out_q;

  logic [PW:0]      shifted, diff;
  logic             ge, rnz;
  logic [DW-1:0]    mag_in;
  logic [QW-1:0]    q0, q_fix;
  logic [PW-1:0]    r_fix;

  // One restoring step, and the sign correction toward minus infinity.
  always_comb begin
    shifted = {rem_q, quo_q[DW-1]};
    ge      = shifted >= {1'b0, dvs_q};
    diff    = shifted - {1'b0, dvs_q};
    mag_in  = dividend_i[DW-1] ? (~dividend_i + 1'b1) : dividend_i;
    q0      = {1'b0, quo_q};
    rnz     = rem_q != '0;
    if (neg_q) begin
      q_fix = rnz ? ~q0 : (~q0 + 1'b1);
    end else begin
      q_fix = q0;
    end
    r_fix = (neg_q && rnz) ? (dvs_q - rem_q) : rem_q;
  end

  // Iteration control and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fix_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          fix_q  <= 1'b1;
        end
      end else if (fix_q) begin
        fix_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DW-1];
      quo_q <= mag_in;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DW-2:0], ge};
      rem_q <= ge ? diff[PW-1:0] : shifted[PW-1:0];
    end
    if (fix_q) begin
      quot_out_q <= q_fix;
      rem_out_q  <= r_fix;
    end
  end

  assign done_o = done_q;
  assign quot_o = $signed(quot_out_q);
  assign rem_o  = rem_out_q;

endmodule

// ----- hw/rtl/rpot_ctrl.sv -----
// Sequencing state machine of the occupancy table: clearing pass, divisions,
// planning, row scan and write passes. Depends on rpot_pkg.
module rpot_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rpot_pkg::dp_status_t status_i,
  output rpot_pkg::ctrl_cmd_t  cmd_o
);

  rpot_pkg::ctrl_state_e state_q, state_d;
  rpot_pkg::div_sel_e    sel_q, sel_d;
  rpot_pkg::div_sel_e    sel_next;

  // Division order: row count, x grid, y grid, then span or last row.
  always_comb begin
    unique case (sel_q)
      rpot_pkg::DV_ROWS: sel_next = rpot_pkg::DV_X;
      rpot_pkg::DV_X:    sel_next = rpot_pkg::DV_Y;
      rpot_pkg::DV_Y:    sel_next = status_i.func_add ? rpot_pkg::DV_LAST : rpot_pkg::DV_NEED;
      default:           sel_next = rpot_pkg::DV_ROWS;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    unique case (state_q)
      rpot_pkg::CS_CLEAR: begin
        if (status_i.clear_last) state_d = rpot_pkg::CS_IDLE;
      end
      rpot_pkg::CS_IDLE: begin
        if (in_valid_i) begin
          state_d = rpot_pkg::CS_DIV_START;
          sel_d   = rpot_pkg::DV_ROWS;
        end
      end
      rpot_pkg::CS_DIV_START: state_d = rpot_pkg::CS_DIV_WAIT;
      rpot_pkg::CS_DIV_WAIT: begin
        if (status_i.div_done) begin
          if (sel_q == rpot_pkg::DV_NEED || sel_q == rpot_pkg::DV_LAST) begin
            state_d = rpot_pkg::CS_PLAN;
          end else begin
            state_d = rpot_pkg::CS_DIV_START;
            sel_d   = sel_next;
          end
        end
      end
      rpot_pkg::CS_PLAN: begin
        state_d = status_i.plan_finish ? rpot_pkg::CS_FINISH : rpot_pkg::CS_SCAN_RD;
      end
      rpot_pkg::CS_SCAN_RD: state_d = rpot_pkg::CS_SCAN_EV;
      rpot_pkg::CS_SCAN_EV: begin
        state_d = (status_i.last_ent && status_i.last_row) ? rpot_pkg::CS_POST
                                                           : rpot_pkg::CS_SCAN_RD;
      end
      rpot_pkg::CS_POST: begin
        state_d = status_i.post_finish ? rpot_pkg::CS_FINISH : rpot_pkg::CS_WR_RD;
      end
      rpot_pkg::CS_WR_RD: state_d = rpot_pkg::CS_WR_EV;
      rpot_pkg::CS_WR_EV: begin
        state_d = (status_i.wr_hit && status_i.last_row) ? rpot_pkg::CS_FINISH
                                                         : rpot_pkg::CS_WR_RD;
      end
      rpot_pkg::CS_FINISH: begin
        if (status_i.out_free) state_d = rpot_pkg::CS_IDLE;
      end
      default: state_d = rpot_pkg::CS_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o             = '0;
    cmd_o.div_sel     = sel_q;
    in_ready_o        = 1'b0;
    unique case (state_q)
      rpot_pkg::CS_CLEAR:     cmd_o.clear_step = 1'b1;
      rpot_pkg::CS_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      rpot_pkg::CS_DIV_START: cmd_o.div_start = 1'b1;
      rpot_pkg::CS_DIV_WAIT:  cmd_o.div_capture = status_i.div_done;
      rpot_pkg::CS_PLAN:      cmd_o.plan = 1'b1;
      rpot_pkg::CS_SCAN_EV:   cmd_o.scan_eval = 1'b1;
      rpot_pkg::CS_POST:      cmd_o.post = 1'b1;
      rpot_pkg::CS_WR_EV:     cmd_o.wr_eval = 1'b1;
      rpot_pkg::CS_FINISH:    cmd_o.out_load = status_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rpot_pkg::CS_CLEAR;
      sel_q   <= rpot_pkg::DV_ROWS;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

endmodule

// ----- hw/rtl/rpot_dp.sv -----
// Datapath of the occupancy table: registers, item capture, shared divider,
// legality planning, entry stores, scan flags and result register.
// Depends on rpot_pkg, rpot_div and rpot_ram.
module rpot_dp #(
  parameter int unsigned MAX_ROWS        = 1024,
  parameter int unsigned ENTRIES_PER_ROW = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rpot_pkg::ctrl_cmd_t                 cmd_i,
  output rpot_pkg::dp_status_t                status_o,
  // configuration writes
  input  logic                                cfg_we_i,
  input  logic [rpot_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [rpot_pkg::COORD_W-1:0]        cfg_data_i,
  // operation item
  input  logic [1:0]                          in_func_i,
  input  logic signed [rpot_pkg::COORD_W-1:0] in_pos_x_i,
  input  logic signed [rpot_pkg::COORD_W-1:0] in_pos_y_i,
  input  logic [rpot_pkg::SIZE_W-1:0]         in_size_w_i,
  input  logic [rpot_pkg::SIZE_W-1:0]         in_size_h_i,
  // result item
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                out_ok_o,
  output logic [2:0]                          out_status_o
);

  localparam int unsigned DEPTH     = MAX_ROWS * ENTRIES_PER_ROW;
  localparam int unsigned AW        = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int unsigned ROW_W     = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned ENT_W     = ENTRIES_PER_ROW > 1 ? $clog2(ENTRIES_PER_ROW) : 1;
  localparam int unsigned ROWCNT_W  = $clog2(MAX_ROWS + 1);
  localparam int unsigned CW        = rpot_pkg::CMP_W;
  localparam int unsigned QW        = rpot_pkg::QUOT_W;
  localparam int unsigned DW        = rpot_pkg::DIV_W;
  localparam int unsigned XW        = rpot_pkg::COORD_W;
  localparam int unsigned PW        = rpot_pkg::PITCH_W;

  // Configuration registers.
  logic signed [XW-1:0] left_q, bottom_q, right_q, top_q;
  logic [PW-1:0]        sw_q, sh_q;
  logic [PW-1:0]        pitch_wr;

  assign pitch_wr = (cfg_data_i[PW-1:0] == '0) ? PW'(1) : cfg_data_i[PW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      bottom_q <= '0;
      right_q  <= '0;
      top_q    <= '0;
      sw_q     <= PW'(1);
      sh_q     <= PW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rpot_pkg::CFG_DIE_LEFT:    left_q   <= cfg_data_i;
        rpot_pkg::CFG_DIE_BOTTOM:  bottom_q <= cfg_data_i;
        rpot_pkg::CFG_DIE_RIGHT:   right_q  <= cfg_data_i;
        rpot_pkg::CFG_DIE_TOP:     top_q    <= cfg_data_i;
        rpot_pkg::CFG_SITE_WIDTH:  sw_q     <= pitch_wr;
        rpot_pkg::CFG_SITE_HEIGHT: sh_q     <= pitch_wr;
        default: ;
      endcase
    end
  end

  // Captured item.
  rpot_pkg::func_e          func_q;
  logic signed [XW-1:0]     x_q, y_q;
  logic [rpot_pkg::SIZE_W-1:0] w_q, h_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      func_q <= rpot_pkg::func_e'(in_func_i);
      x_q    <= in_pos_x_i;
      y_q    <= in_pos_y_i;
      w_q    <= in_size_w_i;
      h_q    <= in_size_h_i;
    end
  end

  // Cell and die extents, one bit wider than the coordinates.
  logic signed [XW:0] xw, yh, right33, top33;
  always_comb begin
    xw      = (XW+1)'(x_q) + $signed({2'b00, w_q});
    yh      = (XW+1)'(y_q) + $signed({2'b00, h_q});
    right33 = (XW+1)'(right_q);
    top33   = (XW+1)'(top_q);
  end

  // Dividend and divisor selection for the shared divider.
  logic signed [DW-1:0] dividend;
  logic [PW-1:0]        divisor;
  logic                 div_done;
  logic signed [QW-1:0] div_quot;
  logic [PW-1:0]        div_rem;

  always_comb begin
    divisor  = sh_q;
    unique case (cmd_i.div_sel)
      rpot_pkg::DV_ROWS: dividend = DW'(top_q) - DW'(bottom_q);
      rpot_pkg::DV_X: begin
        dividend = DW'(x_q) - DW'(left_q);
        divisor  = sw_q;
      end
      rpot_pkg::DV_Y:    dividend = DW'(y_q) - DW'(bottom_q);
      rpot_pkg::DV_NEED: dividend = DW'(h_q) + DW'(sh_q) - DW'(1);
      rpot_pkg::DV_LAST: dividend = DW'(y_q) + DW'(h_q) - DW'(1) - DW'(bottom_q);
      default:           dividend = '0;
    endcase
  end

  rpot_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Division results.
  logic [ROWCNT_W-1:0]  rows_q;
  logic                 rows_zero_q, xrem_nz_q, yrem_nz_q;
  logic signed [QW-1:0] yq_q, need_q, last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_capture) begin
      unique case (cmd_i.div_sel)
        rpot_pkg::DV_ROWS: begin
          rows_zero_q <= div_quot <= 0;
          rows_q <= (div_quot > QW'(MAX_ROWS)) ? ROWCNT_W'(MAX_ROWS)
                                               : div_quot[ROWCNT_W-1:0];
        end
        rpot_pkg::DV_X: xrem_nz_q <= div_rem != '0;
        rpot_pkg::DV_Y: begin
          yrem_nz_q <= div_rem != '0;
          yq_q      <= div_quot;
        end
        rpot_pkg::DV_NEED: need_q <= div_quot;
        rpot_pkg::DV_LAST: last_q <= div_quot;
        default: ;
      endcase
    end
  end

  // Legality planning: either an early status or a row range to scan.
  logic signed [CW-1:0] rows_s, rows_m1, start_s, need_s, end_s, last_s, first_c, last_c;
  logic signed [CW-1:0] plan_lo, plan_hi;
  logic                 plan_finish;
  rpot_pkg::status_e    plan_code;

  always_comb begin
    rows_s   = $signed({{(CW-ROWCNT_W){1'b0}}, rows_q});
    rows_m1  = rows_s - CW'(1);
    start_s  = CW'(yq_q);
    need_s   = CW'(need_q);
    last_s   = CW'(last_q);
    end_s    = start_s + need_s;
    first_c  = (start_s < 0) ? '0 : start_s;
    last_c   = (last_s > rows_m1) ? rows_m1 : last_s;
    plan_lo  = start_s;
    plan_hi  = end_s - CW'(1);
    plan_finish = 1'b1;
    plan_code   = rpot_pkg::ST_DONE;
    if (rows_zero_q) begin
      plan_code = rpot_pkg::ST_NO_ROWS;
    end else begin
      unique case (func_q)
        rpot_pkg::FN_ADD_OBST: begin
          plan_lo = first_c;
          plan_hi = last_c;
          priority if (w_q == '0 || h_q == '0 ||
                       !(x_q < right_q && (XW+1)'(left_q) < xw)) begin
            plan_code = rpot_pkg::ST_DONE;
          end else if (first_c > last_c) begin
            plan_code = rpot_pkg::ST_DONE;
          end else begin
            plan_finish = 1'b0;
          end
        end
        rpot_pkg::FN_UNCOMMIT: begin
          priority if (yrem_nz_q) begin
            plan_code = rpot_pkg::ST_OFF_GRID;
          end else if (start_s < 0 || start_s >= rows_s || end_s > rows_s) begin
            plan_code = rpot_pkg::ST_OUTSIDE;
          end else if (need_s == 0) begin
            plan_code = rpot_pkg::ST_DONE;
          end else begin
            plan_finish = 1'b0;
          end
        end
        default: begin
          priority if (xrem_nz_q || yrem_nz_q) begin
            plan_code = rpot_pkg::ST_OFF_GRID;
          end else if (x_q < left_q || y_q < bottom_q || xw > right33 || yh > top33) begin
            plan_code = rpot_pkg::ST_OUTSIDE;
          end else if (start_s >= rows_s || end_s > rows_s) begin
            plan_code = rpot_pkg::ST_OUTSIDE;
          end else if (need_s == 0) begin
            plan_code = rpot_pkg::ST_DONE;
          end else if (w_q == '0) begin
            plan_code = rpot_pkg::ST_OUTSIDE;
          end else begin
            plan_finish = 1'b0;
          end
        end
      endcase
    end
  end

  // Row and entry walk over the spanned rows, plus the clearing sweep.
  logic [ROW_W-1:0] row_q, lo_q, hi_q;
  logic [ENT_W-1:0] ent_q;
  logic [AW-1:0]    clr_q, cur_addr;
  logic             last_ent, last_row, clear_last;

  assign cur_addr   = AW'(row_q) * AW'(ENTRIES_PER_ROW) + AW'(ent_q);
  assign last_ent   = ent_q == ENT_W'(ENTRIES_PER_ROW - 1);
  assign last_row   = row_q == hi_q;
  assign clear_last = clr_q == AW'(DEPTH - 1);

  // Entry stores.
  logic [1:0]        kind_rd, kind_wr;
  logic [2*XW-1:0]   lr_rd, lr_wr;
  logic              kind_we, lr_we, wr_hit;

  rpot_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_kind_ram (
    .clk_i   (clk_i),
    .we_i    (kind_we),
    .waddr_i (cmd_i.clear_step ? clr_q : cur_addr),
    .wdata_i (cmd_i.clear_step ? rpot_pkg::KIND_EMPTY : kind_wr),
    .raddr_i (cur_addr),
    .rdata_o (kind_rd)
  );

  rpot_ram #(.WIDTH(2*XW), .DEPTH(DEPTH)) u_lr_ram (
    .clk_i   (clk_i),
    .we_i    (lr_we),
    .waddr_i (cur_addr),
    .wdata_i (lr_wr),
    .raddr_i (cur_addr),
    .rdata_o (lr_rd)
  );

  // Entry compare against the cell interval [x, x+w).
  logic signed [XW-1:0] el, er, clip_l, clip_r;
  logic signed [XW:0]   el33, er33;
  logic                 ov, exact, is_empty, is_obst, is_cell;

  always_comb begin
    el       = lr_rd[2*XW-1:XW];
    er       = lr_rd[XW-1:0];
    el33     = (XW+1)'(el);
    er33     = (XW+1)'(er);
    ov       = (el33 < xw) && (x_q < er);
    exact    = (el == x_q) && (er33 == xw);
    is_empty = kind_rd == rpot_pkg::KIND_EMPTY;
    is_obst  = kind_rd == rpot_pkg::KIND_OBST;
    is_cell  = kind_rd == rpot_pkg::KIND_CELL;
    clip_l   = (x_q > left_q) ? x_q : left_q;
    clip_r   = (xw < right33) ? xw[XW-1:0] : right_q;
  end

  // Write pass: first empty entry for add and commit, first exact cell for uncommit.
  always_comb begin
    unique case (func_q)
      rpot_pkg::FN_ADD_OBST: begin
        wr_hit  = is_empty;
        kind_wr = rpot_pkg::KIND_OBST;
        lr_wr   = {clip_l, clip_r};
      end
      rpot_pkg::FN_UNCOMMIT: begin
        wr_hit  = is_cell && exact;
        kind_wr = rpot_pkg::KIND_EMPTY;
        lr_wr   = {clip_l, clip_r};
      end
      default: begin
        wr_hit  = is_empty;
        kind_wr = rpot_pkg::KIND_CELL;
        lr_wr   = {x_q, xw[XW-1:0]};
      end
    endcase
    kind_we = cmd_i.clear_step || (cmd_i.wr_eval && wr_hit);
    lr_we   = cmd_i.wr_eval && wr_hit && (func_q != rpot_pkg::FN_UNCOMMIT);
  end

  // Scan flags and the decision after the scan pass.
  logic obst_hit_q, cell_hit_q, full_q, miss_q, row_free_q, row_match_q;
  logic row_free, row_match;
  logic post_finish;
  rpot_pkg::status_e post_code, res_q;

  assign row_free  = row_free_q || is_empty;
  assign row_match = row_match_q || (is_cell && exact);

  always_comb begin
    post_finish = 1'b1;
    post_code   = rpot_pkg::ST_DONE;
    unique case (func_q)
      rpot_pkg::FN_ADD_OBST: begin
        if (full_q) post_code = rpot_pkg::ST_FULL;
        else        post_finish = 1'b0;
      end
      rpot_pkg::FN_CHECK: begin
        priority if (obst_hit_q) post_code = rpot_pkg::ST_OBSTACLE;
        else if (cell_hit_q)     post_code = rpot_pkg::ST_OVERLAP;
        else                     post_code = rpot_pkg::ST_DONE;
      end
      rpot_pkg::FN_COMMIT: begin
        priority if (obst_hit_q) post_code = rpot_pkg::ST_OBSTACLE;
        else if (cell_hit_q)     post_code = rpot_pkg::ST_OVERLAP;
        else if (full_q)         post_code = rpot_pkg::ST_FULL;
        else                     post_finish = 1'b0;
      end
      rpot_pkg::FN_UNCOMMIT: begin
        if (miss_q) post_code = rpot_pkg::ST_NOT_FOUND;
        else        post_finish = 1'b0;
      end
      default: ;
    endcase
  end

  // Walk counters, flags and result code.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_step) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.plan) begin
      res_q       <= plan_code;
      row_q       <= ROW_W'(plan_lo);
      lo_q        <= ROW_W'(plan_lo);
      hi_q        <= ROW_W'(plan_hi);
      ent_q       <= '0;
      obst_hit_q  <= 1'b0;
      cell_hit_q  <= 1'b0;
      full_q      <= 1'b0;
      miss_q      <= 1'b0;
      row_free_q  <= 1'b0;
      row_match_q <= 1'b0;
    end else if (cmd_i.scan_eval) begin
      if (is_obst && ov) obst_hit_q <= 1'b1;
      if (is_cell && ov) cell_hit_q <= 1'b1;
      if (last_ent) begin
        if (!row_free)  full_q <= 1'b1;
        if (!row_match) miss_q <= 1'b1;
        row_free_q  <= 1'b0;
        row_match_q <= 1'b0;
        ent_q       <= '0;
        row_q       <= row_q + 1'b1;
      end else begin
        row_free_q  <= row_free;
        row_match_q <= row_match;
        ent_q       <= ent_q + 1'b1;
      end
    end else if (cmd_i.post) begin
      res_q <= post_code;
      row_q <= lo_q;
      ent_q <= '0;
    end else if (cmd_i.wr_eval) begin
      if (wr_hit) begin
        ent_q <= '0;
        row_q <= row_q + 1'b1;
      end else begin
        ent_q <= ent_q + 1'b1;
      end
    end
  end

  // Result register toward the output channel.
  logic       out_valid_q;
  logic [2:0] out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) out_status_q <= res_q;
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_ok_o     = out_status_q == rpot_pkg::ST_DONE;

  always_comb begin
    status_o.clear_last  = clear_last;
    status_o.func_add    = func_q == rpot_pkg::FN_ADD_OBST;
    status_o.div_done    = div_done;
    status_o.plan_finish = plan_finish;
    status_o.last_ent    = last_ent;
    status_o.last_row    = last_row;
    status_o.post_finish = post_finish;
    status_o.wr_hit      = wr_hit;
    status_o.out_free    = !out_valid_q || out_ready_i;
  end

endmodule

// ----- hw/rtl/row_placement_occupancy_table.sv -----
// Top level of the row placement occupancy table.
// Depends on rpot_pkg, rpot_if, rpot_ctrl and rpot_dp.
//
// Usage: item_i carries one operation (add obstacle, check, commit,
// uncommit) with a lower-left corner and a size; result_o returns one item
// per operation with ok and a status code. cfg_i writes the die corners and
// the site pitches, indexed in that order; it is always ready and is meant
// to be written only while no operation is in flight.
// After reset the block runs a clearing pass over all
// MAX_ROWS * ENTRIES_PER_ROW kind entries, one per cycle, and takes no
// item until it ends; configuration writes are taken during the pass.
// One item at a time is worked on. Each takes four divisions on the shared
// bit-serial divider, a planning step, then a read and an evaluate step per
// entry over every spanned row for the scan pass, and for add, commit and
// uncommit a write pass of a read and an evaluate step per entry until the
// target entry of each row is found. Both passes share one entry-store port.
// The result sits in an output register; the next item is taken while it
// waits, and a held result only stalls the finishing of the following item.
module row_placement_occupancy_table #(
  parameter int unsigned MAX_ROWS        = 1024,
  parameter int unsigned ENTRIES_PER_ROW = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rpot_item_if.sink   item_i,
  rpot_res_if.source  result_o,
  rpot_cfg_if.sink    cfg_i
);

  rpot_pkg::ctrl_cmd_t  cmd;
  rpot_pkg::dp_status_t status;
  logic                 in_ready;

  assign item_i.ready = in_ready;
  assign cfg_i.ready  = 1'b1;

  rpot_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rpot_dp #(
    .MAX_ROWS        (MAX_ROWS),
    .ENTRIES_PER_ROW (ENTRIES_PER_ROW)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_we_i     (cfg_i.valid),
    .cfg_index_i  (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .in_func_i    (item_i.func),
    .in_pos_x_i   (item_i.pos_x),
    .in_pos_y_i   (item_i.pos_y),
    .in_size_w_i  (item_i.size_w),
    .in_size_h_i  (item_i.size_h),
    .out_valid_o  (result_o.valid),
    .out_ready_i  (result_o.ready),
    .out_ok_o     (result_o.ok),
    .out_status_o (result_o.status)
  );

endmodule
